FILE: hw/rtl/rsd_pkg.sv
// Package for the rANS symbol decoder: transaction structs, codes, FSM states.
// No dependencies.
`default_nettype none
package rsd_pkg;

    typedef enum logic [1:0] {
        ACT_CLEAR  = 2'd0,
        ACT_APPEND = 2'd1,
        ACT_FEED   = 2'd2,
        ACT_DECODE = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NEED      = 2'd1,
        ST_INVALID   = 2'd2,
        ST_TOO_LARGE = 2'd3
    } status_t;

    typedef struct packed {
        action_t     action;
        logic [31:0] token;
        logic [30:0] entry_frequency;
        logic [31:0] symbol_delta;
    } cmd_t;

    typedef struct packed {
        status_t     status;
        logic [31:0] symbol;
    } result_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_SRCH_RD,
        S_SRCH_CMP,
        S_FETCH,
        S_CHECK,
        S_MUL_HI,
        S_FINISH
    } fsm_t;

    localparam logic [31:0] HALF_RANGE = 32'h8000_0000;
    localparam int          DIV_STEPS  = 64;

endpackage
`default_nettype wire

FILE: hw/rtl/rans_symbol_decoder.sv
// rANS symbol decoder top level: table memory, bit-serial divider, search, multiplier.
// Depends on rsd_pkg.
`default_nettype none
// Usage: drive cmd and raise start; the transaction is taken at an edge where busy
// is low. Every transaction gives one result on result, marked by strobe for one
// cycle; the receiver cannot stall it.
// Clear, append and feed never raise busy: strobe follows in the next cycle and a new
// transaction may be taken there too.
// Decode with a valid table and enough state runs a restoring divider of one
// quotient bit per cycle, then a lo/hi binary search over the start table with
// one registered memory read per probe (a read step and a compare step per probe,
// plus a closing step when no start matches exactly), then a table fetch, and two
// 32x31 partial products through one shared multiplier; strobe comes in the same
// cycle that busy falls.
// Early decode rejections (invalid or need token) never raise busy either.
// Reset (rst_n low, asynchronous) empties the table and zeroes the coder state;
// table memory contents are not cleared and are never used before they are written.
module rans_symbol_decoder
    import rsd_pkg::*;
#(
    parameter int TABLE_DEPTH = 256
) (
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    start,
    input  wire cmd_t    cmd,
    output logic         busy,
    output logic         strobe,
    output result_t      result
);

    localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

    logic [30:0] start_mem [TABLE_DEPTH];
    logic [30:0] freq_mem  [TABLE_DEPTH];
    logic [31:0] sym_mem   [TABLE_DEPTH];

    fsm_t        state_reg, state_next;
    logic [63:0] coder_reg, coder_next;
    logic [CW-1:0] n_reg, n_next;
    logic [31:0] fs_reg, fs_next;
    logic [31:0] prev_reg, prev_next;
    logic [30:0] total_reg, total_next;
    logic [30:0] rem_reg, rem_next;
    logic [63:0] quot_reg, quot_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic [CW-1:0] lo_reg, lo_next, hi_reg, hi_next;
    logic [IW-1:0] idx_reg, idx_next;
    logic [30:0] f_reg, f_next;
    logic [30:0] s_reg, s_next;
    logic [31:0] sym_reg, sym_next;
    logic [62:0] prod_reg, prod_next;
    logic [63:0] acc_reg, acc_next;
    logic        strobe_reg, strobe_next;
    result_t     result_reg, result_next;

    logic [30:0] rd_start_reg, rd_freq_reg;
    logic [31:0] rd_sym_reg;
    logic [IW-1:0] rd_addr;

    logic        mem_we;
    logic [IW-1:0] mem_waddr;

    logic        accept;
    logic [32:0] sym_sum;
    logic [32:0] fs_sum;
    logic [31:0] dec_total;
    logic [31:0] trial;
    logic [CW-1:0] mid;
    logic [30:0] f_cur;
    logic [31:0] mul_a;
    logic [30:0] mul_b;
    logic [62:0] mul_p;
    logic [30:0] c_minus_s;

    assign accept    = start && (state_reg == S_IDLE);
    assign sym_sum   = {1'b0, prev_reg} + {1'b0, cmd.symbol_delta};
    assign fs_sum    = {1'b0, fs_reg} + {2'b0, cmd.entry_frequency};
    assign dec_total = (n_reg == CW'(1)) ? 32'd2 : fs_reg;
    assign trial     = {rem_reg, quot_reg[63]};
    assign mid       = lo_reg + ((hi_reg - lo_reg) >> 1);
    assign f_cur     = (n_reg == CW'(1)) ? 31'd1 : rd_freq_reg;
    assign mul_a     = (state_reg == S_CHECK) ? quot_reg[31:0] : quot_reg[63:32];
    assign mul_b     = (state_reg == S_CHECK) ? f_cur : f_reg;
    assign mul_p     = 63'(mul_a * mul_b);
    assign c_minus_s = rem_reg - s_reg;

    assign mem_we    = accept && (cmd.action == ACT_APPEND) && (n_reg < DEPTH_C)
                       && !sym_sum[32];
    assign mem_waddr = n_reg[IW-1:0];

    always_comb
    begin
        case (state_reg)
            S_SRCH_RD: rd_addr = mid[IW-1:0];
            default:   rd_addr = idx_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            start_mem[mem_waddr] <= fs_reg[30:0];
            freq_mem[mem_waddr]  <= cmd.entry_frequency;
            sym_mem[mem_waddr]   <= sym_sum[31:0];
        end
    end

    always_ff @(posedge clk)
    begin
        rd_start_reg <= start_mem[rd_addr];
        rd_freq_reg  <= freq_mem[rd_addr];
        rd_sym_reg   <= sym_mem[rd_addr];
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept && (cmd.action == ACT_DECODE) && (n_reg != '0)
                    && (dec_total != 32'd0) && !dec_total[31]
                    && (coder_reg[63:31] != '0))
                    state_next = S_DIV;
            end
            S_DIV:      if (cnt_reg == 6'(DIV_STEPS - 1)) state_next = S_SRCH_RD;
            S_SRCH_RD:  state_next = (lo_reg < hi_reg) ? S_SRCH_CMP : S_FETCH;
            S_SRCH_CMP:
            begin
                if (rd_start_reg == rem_reg) state_next = S_FETCH;
                else                         state_next = S_SRCH_RD;
            end
            S_FETCH:    state_next = S_CHECK;
            S_CHECK:
            begin
                if ((f_cur == '0) || (rem_reg < rd_start_reg)) state_next = S_IDLE;
                else                                           state_next = S_MUL_HI;
            end
            S_MUL_HI:   state_next = S_FINISH;
            S_FINISH:   state_next = S_IDLE;
            default:    state_next = S_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        coder_next  = coder_reg;
        n_next      = n_reg;
        fs_next     = fs_reg;
        prev_next   = prev_reg;
        total_next  = total_reg;
        rem_next    = rem_reg;
        quot_next   = quot_reg;
        cnt_next    = cnt_reg;
        lo_next     = lo_reg;
        hi_next     = hi_reg;
        idx_next    = idx_reg;
        f_next      = f_reg;
        s_next      = s_reg;
        sym_next    = sym_reg;
        prod_next   = prod_reg;
        acc_next    = acc_reg;
        strobe_next = 1'b0;
        result_next = '{status: ST_OK, symbol: 32'd0};
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    strobe_next = 1'b1;
                    case (cmd.action)
                        ACT_CLEAR:
                        begin
                            n_next     = '0;
                            fs_next    = '0;
                            prev_next  = '0;
                            coder_next = '0;
                        end
                        ACT_APPEND:
                        begin
                            if ((n_reg >= DEPTH_C) || sym_sum[32])
                            begin
                                n_next    = '0;
                                fs_next   = '0;
                                prev_next = '0;
                                result_next.status = ST_TOO_LARGE;
                            end
                            else
                            begin
                                prev_next = sym_sum[31:0];
                                n_next    = n_reg + CW'(1);
                                fs_next   = (fs_sum > {1'b0, HALF_RANGE}) ? HALF_RANGE
                                                                           : fs_sum[31:0];
                            end
                        end
                        ACT_FEED:
                        begin
                            if (coder_reg[63:31] != '0)
                                result_next.status = ST_INVALID;
                            else
                                coder_next = {coder_reg[31:0], cmd.token};
                        end
                        default:
                        begin
                            if ((n_reg == '0) || (dec_total == 32'd0) || dec_total[31])
                                result_next.status = ST_INVALID;
                            else if (coder_reg[63:31] == '0)
                                result_next.status = ST_NEED;
                            else
                            begin
                                strobe_next = 1'b0;
                                total_next  = dec_total[30:0];
                                rem_next    = '0;
                                quot_next   = coder_reg;
                                cnt_next    = '0;
                            end
                        end
                    endcase
                end
            end
            S_DIV:
            begin
                // restoring step: remainder stays below total, so 31 bits suffice
                if (trial >= {1'b0, total_reg})
                begin
                    rem_next  = 31'(trial - {1'b0, total_reg});
                    quot_next = {quot_reg[62:0], 1'b1};
                end
                else
                begin
                    rem_next  = trial[30:0];
                    quot_next = {quot_reg[62:0], 1'b0};
                end
                cnt_next = cnt_reg + 6'd1;
                lo_next  = '0;
                hi_next  = n_reg;
            end
            S_SRCH_RD:
            begin
                if (lo_reg < hi_reg)
                    idx_next = mid[IW-1:0];
                else
                    idx_next = (lo_reg != '0) ? IW'(lo_reg - CW'(1)) : '0;
            end
            S_SRCH_CMP:
            begin
                // idx_reg holds mid of this probe
                if (rd_start_reg < rem_reg)
                    lo_next = CW'(idx_reg) + CW'(1);
                else if (rd_start_reg != rem_reg)
                    hi_next = CW'(idx_reg);
            end
            S_CHECK:
            begin
                if ((f_cur == '0) || (rem_reg < rd_start_reg))
                begin
                    strobe_next = 1'b1;
                    result_next.status = ST_INVALID;
                end
                else
                begin
                    f_next    = f_cur;
                    s_next    = rd_start_reg;
                    sym_next  = rd_sym_reg;
                    prod_next = mul_p;
                end
            end
            S_MUL_HI:
            begin
                acc_next  = {1'b0, prod_reg} + {33'd0, c_minus_s};
                prod_next = mul_p;
            end
            S_FINISH:
            begin
                coder_next  = acc_reg + {prod_reg[31:0], 32'd0};
                strobe_next = 1'b1;
                result_next = '{status: ST_OK, symbol: sym_reg};
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            coder_reg  <= '0;
            n_reg      <= '0;
            fs_reg     <= '0;
            prev_reg   <= '0;
            cnt_reg    <= '0;
            lo_reg     <= '0;
            hi_reg     <= '0;
            idx_reg    <= '0;
            strobe_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            coder_reg  <= coder_next;
            n_reg      <= n_next;
            fs_reg     <= fs_next;
            prev_reg   <= prev_next;
            cnt_reg    <= cnt_next;
            lo_reg     <= lo_next;
            hi_reg     <= hi_next;
            idx_reg    <= idx_next;
            strobe_reg <= strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        total_reg  <= total_next;
        rem_reg    <= rem_next;
        quot_reg   <= quot_next;
        f_reg      <= f_next;
        s_reg      <= s_next;
        sym_reg    <= sym_next;
        prod_reg   <= prod_next;
        acc_reg    <= acc_next;
        result_reg <= result_next;
    end

    assign busy   = (state_reg != S_IDLE);
    assign strobe = strobe_reg;
    assign result = result_reg;

    a_short_txn: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (cmd.action != ACT_DECODE)) |=> strobe)
        else $error("single-cycle transaction gave no result");

    a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
        strobe |-> !busy)
        else $error("result issued while a decode is still running");

    a_sym_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && (result.status != ST_OK)) |-> (result.symbol == 32'd0))
        else $error("symbol not zero on a failed transaction");

    a_fill: assert property (@(posedge clk) disable iff (!rst_n)
        n_reg <= DEPTH_C)
        else $error("entry count beyond table depth");

endmodule
`default_nettype wire

FILE: bench/testbench.sv
// Self-checking testbench for rans_symbol_decoder: drives clear/append/feed/decode
// transactions and checks every result against a built-in predictor.
// Depends on rsd_pkg and the rans_symbol_decoder RTL.
`default_nettype none

class rans_scoreboard;
    rsd_pkg::result_t pending[$];
    int errors;

    // predictor state
    logic [63:0] coder;
    logic [30:0] starts [256];
    logic [30:0] freqs [256];
    logic [31:0] syms [256];
    int unsigned used;
    logic [31:0] fsum;
    logic [31:0] prev_sym;

    function new();
        errors = 0;
        coder = '0;
        used = 0;
        fsum = '0;
        prev_sym = '0;
    endfunction

    function int unsigned search_start(logic [63:0] c);
        int unsigned lo;
        int unsigned hi;
        int unsigned mid;
        lo = 0;
        hi = used;
        while (lo < hi)
        begin
            mid = lo + (hi - lo) / 2;
            if ({33'd0, starts[mid]} == c)
                return mid;
            if ({33'd0, starts[mid]} < c)
                lo = mid + 1;
            else
                hi = mid;
        end
        return (lo != 0) ? lo - 1 : 0;
    endfunction

    function void note_cmd(rsd_pkg::cmd_t cmd);
        rsd_pkg::result_t r;
        logic [63:0] total;
        logic [63:0] c;
        logic [63:0] f;
        logic [63:0] s;
        logic [32:0] sum;
        int unsigned idx;
        r.status = rsd_pkg::ST_OK;
        r.symbol = '0;
        case (cmd.action)
            rsd_pkg::ACT_CLEAR:
            begin
                used = 0; fsum = 0; prev_sym = 0; coder = 0;
            end
            rsd_pkg::ACT_APPEND:
            begin
                if (used >= 256 || cmd.symbol_delta > 32'hFFFF_FFFF - prev_sym)
                begin
                    used = 0; fsum = 0; prev_sym = 0;
                    r.status = rsd_pkg::ST_TOO_LARGE;
                end
                else
                begin
                    prev_sym = prev_sym + cmd.symbol_delta;
                    starts[used] = fsum[30:0];
                    freqs[used] = cmd.entry_frequency;
                    syms[used] = prev_sym;
                    used++;
                    sum = {1'b0, fsum} + {2'b0, cmd.entry_frequency};
                    fsum = (sum > 33'h8000_0000) ? 32'h8000_0000 : sum[31:0];
                end
            end
            rsd_pkg::ACT_FEED:
            begin
                if (coder >= 64'h8000_0000)
                    r.status = rsd_pkg::ST_INVALID;
                else
                    coder = {coder[31:0], cmd.token};
            end
            default:
            begin
                total = (used == 1) ? 64'd2 : {32'd0, fsum};
                if (used == 0 || total == 0 || total >= 64'h8000_0000)
                    r.status = rsd_pkg::ST_INVALID;
                else if (coder < 64'h8000_0000)
                    r.status = rsd_pkg::ST_NEED;
                else
                begin
                    c = coder % total;
                    idx = search_start(c);
                    f = (used == 1) ? 64'd1 : {33'd0, freqs[idx]};
                    s = {33'd0, starts[idx]};
                    if (idx >= used || f == 0 || c < s)
                        r.status = rsd_pkg::ST_INVALID;
                    else
                    begin
                        r.symbol = syms[idx];
                        coder = (coder / total) * f + (c - s);
                    end
                end
            end
        endcase
        pending.push_back(r);
    endfunction

    function void check_result(rsd_pkg::result_t got);
        rsd_pkg::result_t exp_r;
        if (pending.size() == 0)
        begin
            $display("%0t: unexpected result status=%0d symbol=%h", $time,
                     got.status, got.symbol);
            errors++;
            return;
        end
        exp_r = pending.pop_front();
        if (got.status !== exp_r.status)
        begin
            $display("%0t: status expected %0d actual %0d", $time, exp_r.status, got.status);
            errors++;
        end
        if (got.symbol !== exp_r.symbol)
        begin
            $display("%0t: symbol expected %h actual %h", $time, exp_r.symbol, got.symbol);
            errors++;
        end
    endfunction
endclass

module testbench;
    import rsd_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    logic clk;
    logic rst_n;
    logic start;
    cmd_t cmd;
    logic busy;
    logic strobe;
    result_t result;

    rans_scoreboard board;
    int send_idle;

    rans_symbol_decoder DUT (
        .clk(clk), .rst_n(rst_n), .start(start), .cmd(cmd),
        .busy(busy), .strobe(strobe), .result(result)
    );

    initial clk = 1'b0;
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    initial
    begin
        #2_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    always @(posedge clk)
        if (rst_n && strobe)
            board.check_result(result);

    // one transaction; start stays high across back-to-back items
    task automatic send(action_t a, logic [31:0] tok, logic [30:0] fr, logic [31:0] dl);
        while ($urandom_range(99) < send_idle)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start <= 1'b1;
        cmd <= '{action: a, token: tok, entry_frequency: fr, symbol_delta: dl};
        @(posedge clk);
        while (busy)
            @(posedge clk);
        board.note_cmd(cmd);
    endtask

    task automatic drain();
        start <= 1'b0;
        while (board.pending.size() != 0)
            @(posedge clk);
    endtask

    // a table of n appends with small, sometimes zero frequencies, then a state
    task automatic load_table(int n);
        send(ACT_CLEAR, $urandom, 31'($urandom), $urandom);
        for (int i = 0; i < n; i++)
            send(ACT_APPEND, $urandom, 31'($urandom_range(($urandom_range(9) == 0) ? 0 : 1, 40)),
                 ($urandom_range(7) == 0) ? $urandom : 32'($urandom_range(3)));
        send(ACT_FEED, $urandom, 31'($urandom), $urandom);
        send(ACT_FEED, $urandom | 32'h8000_0000, 31'($urandom), $urandom);
    endtask

    task automatic random_item();
        int k;
        k = $urandom_range(99);
        if (k < 3)
            send(ACT_CLEAR, $urandom, 31'($urandom), $urandom);
        else if (k < 12)
            send(ACT_APPEND, $urandom, ($urandom_range(3) == 0) ? 31'($urandom) :
                 31'($urandom_range(50)), ($urandom_range(5) == 0) ? $urandom :
                 32'($urandom_range(5)));
        else if (k < 30)
            send(ACT_FEED, $urandom, 31'($urandom), $urandom);
        else
            send(ACT_DECODE, $urandom, 31'($urandom), $urandom);
    endtask

    initial
    begin
        board = new();
        rst_n = 1'b0;
        start = 1'b0;
        cmd = '0;
        send_idle = 7;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty table, need token, invalid feed, single entry, overflows
        send(ACT_DECODE, '0, '0, '0);
        send(ACT_APPEND, '1, 31'h7FFF_FFFF, 32'hFFFF_FFFF);
        send(ACT_DECODE, '0, '0, '0);
        send(ACT_APPEND, '0, 31'd1, 32'd1);
        send(ACT_CLEAR, '0, '0, '0);
        send(ACT_APPEND, '0, 31'd0, 32'd7);
        send(ACT_DECODE, '0, '0, '0);
        send(ACT_FEED, 32'hFFFF_FFFF, '0, '0);
        send(ACT_FEED, 32'h1234_5678, '0, '0);
        send(ACT_DECODE, '0, '0, '0);
        send(ACT_DECODE, '0, '0, '0);
        send(ACT_APPEND, '0, 31'd3, 32'd0);
        send(ACT_APPEND, '0, 31'd0, 32'd2);
        send(ACT_APPEND, '0, 31'd5, 32'd1);
        send(ACT_DECODE, '0, '0, '0);
        send(ACT_DECODE, '0, '0, '0);
        send(ACT_FEED, '0, '0, '0);
        send(ACT_APPEND, '0, 31'h7FFF_FFFF, 32'd0);
        send(ACT_DECODE, '0, '0, '0);
        send(ACT_CLEAR, '0, '0, '0);
        send(ACT_APPEND, '0, 31'd1, 32'hFFFF_FFFF);
        send(ACT_APPEND, '0, 31'd1, 32'd1);
        // full table overflow
        for (int i = 0; i < 257; i++)
            send(ACT_APPEND, '0, 31'd1, 32'd0);
        drain();

        for (int phase = 0; phase < 3; phase++)
        begin
            send_idle = (phase == 0) ? 7 : (phase == 1) ? 72 : 0;
            for (int blk = 0; blk < 5; blk++)
            begin
                load_table(($urandom_range(9) == 0) ? 256 : $urandom_range(1, 12));
                repeat ($urandom_range(10, 30))
                begin
                    if ($urandom_range(4) == 0)
                        random_item();
                    else if ($urandom_range(3) == 0)
                        send(ACT_FEED, $urandom, 31'($urandom), $urandom);
                    else
                        send(ACT_DECODE, $urandom, 31'($urandom), $urandom);
                end
                if (blk == 2)
                    drain();
            end
        end
        drain();
        repeat (100) @(posedge clk);
        if (board.errors == 0 && board.pending.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule
`default_nettype wire

FILE: sim.f
hw/rtl/rsd_pkg.sv
hw/rtl/rans_symbol_decoder.sv
bench/testbench.sv
